[sv/u2c_pkg.sv]
// Shared types and the code point to Windows-1252 mapping for the decoder.
// No dependencies; used by u2c_decode and utf8_to_cp1252_decoder_unit.
package u2c_pkg;

  // Field widths
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CodeW  = 16;
  localparam int unsigned TailW  = 2;

  // Lead byte bounds and the plain Latin-1 range
  localparam logic [ByteW-1:0] Lead2Lo  = 8'hc2;
  localparam logic [ByteW-1:0] Lead2Hi  = 8'hdf;
  localparam logic [ByteW-1:0] Lead3Lo  = 8'he0;
  localparam logic [ByteW-1:0] Lead3Hi  = 8'hef;
  localparam logic [CodeW-1:0] Latin1Lo = 16'h00a0;
  localparam logic [CodeW-1:0] Latin1Hi = 16'h00ff;

  // Pending tail counts
  localparam logic [TailW-1:0] TailNone = 2'd0;
  localparam logic [TailW-1:0] TailOne  = 2'd1;
  localparam logic [TailW-1:0] TailTwo  = 2'd2;

  // Outcome of one decode step
  typedef struct packed {
    logic             emit;
    logic             bad;
    logic [ByteW-1:0] data;
  } dec_res_t;

  // Map a finished code point; bit 8 is the hit flag, bits 7:0 the byte.
  function automatic logic [ByteW:0] map_cp(input logic [CodeW-1:0] cp);
    logic [ByteW:0] res;
    res = '0;
    if (cp >= Latin1Lo && cp <= Latin1Hi) begin
      res = {1'b1, cp[ByteW-1:0]};
    end else begin
      case (cp)
        16'h20ac: res = {1'b1, 8'h80};
        16'h201a: res = {1'b1, 8'h82};
        16'h0192: res = {1'b1, 8'h83};
        16'h201e: res = {1'b1, 8'h84};
        16'h2026: res = {1'b1, 8'h85};
        16'h2020: res = {1'b1, 8'h86};
        16'h2021: res = {1'b1, 8'h87};
        16'h02c6: res = {1'b1, 8'h88};
        16'h2030: res = {1'b1, 8'h89};
        16'h0160: res = {1'b1, 8'h8a};
        16'h2039: res = {1'b1, 8'h8b};
        16'h0152: res = {1'b1, 8'h8c};
        16'h017d: res = {1'b1, 8'h8e};
        16'h2018: res = {1'b1, 8'h91};
        16'h2019: res = {1'b1, 8'h92};
        16'h201c: res = {1'b1, 8'h93};
        16'h201d: res = {1'b1, 8'h94};
        16'h2022: res = {1'b1, 8'h95};
        16'h2013: res = {1'b1, 8'h96};
        16'h2014: res = {1'b1, 8'h97};
        16'h02dc: res = {1'b1, 8'h98};
        16'h2122: res = {1'b1, 8'h99};
        16'h0161: res = {1'b1, 8'h9a};
        16'h203a: res = {1'b1, 8'h9b};
        16'h0153: res = {1'b1, 8'h9c};
        16'h017e: res = {1'b1, 8'h9e};
        16'h0178: res = {1'b1, 8'h9f};
        default:  res = '0;
      endcase
    end
    return res;
  endfunction

endpackage

[sv/utf8_to_cp1252_decoder_unit.sv]
// UTF-8 to Windows-1252 decoder: takes one UTF-8 byte per beat and gives at
// most one Windows-1252 byte per beat, with a flag for malformed or unmappable
// input. Throughput is one byte per cycle while the input is not stalled; the
// last byte of a sequence passes from the input register through the
// combinational decode step into the result register, which presents the
// result. Lead and middle bytes of a multi-byte sequence give no result. The
// input side keeps taking beats while a result waits, and stalls only when
// the result register is full and stalled with a new result due.
// Depends on u2c_pkg and u2c_decode.
module utf8_to_cp1252_decoder_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [u2c_pkg::ByteW-1:0] in_byte,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [u2c_pkg::ByteW-1:0] out_byte,
  output logic                      out_bad_sequence
);

  logic                      hold_vld_r;
  logic [u2c_pkg::ByteW-1:0] hold_byte_r;
  logic                      out_vld_r;
  logic [u2c_pkg::ByteW-1:0] out_byte_r;
  logic                      out_bad_r;
  logic                      out_free;
  logic                      step;
  u2c_pkg::dec_res_t         res;

  // Move the held beat on when its result, if any, has room
  assign out_free = ~out_vld_r | ~out_stall;
  assign step     = hold_vld_r & (~res.emit | out_free);
  assign in_stall = hold_vld_r & ~step;

  u2c_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .byte_in (hold_byte_r),
    .res     (res)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_vld_r <= 1'b0;
    end else if (!in_stall) begin
      hold_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      hold_byte_r <= in_byte;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= step & res.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res.emit) begin
      out_byte_r <= res.data;
      out_bad_r  <= res.bad;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_byte         = out_byte_r;
  assign out_bad_sequence = out_bad_r;

`ifndef SYNTH
  // Input stalls only while a beat is held
  a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> hold_vld_r) else $error("stall with empty input register");

  // A flagged result carries a zero byte
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_bad_r |-> out_byte_r == '0) else $error("bad result with data");

  // A stalled result is not lost
  a_out_kept: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_stall |=> out_vld_r) else $error("stalled result dropped");
`endif

endmodule

[sv/u2c_decode.sv]
// Per-byte UTF-8 decode step with the pending sequence state.
// Depends on u2c_pkg for widths, bounds, result type and the mapping.
module u2c_decode (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      step,
  input  logic [u2c_pkg::ByteW-1:0] byte_in,
  output u2c_pkg::dec_res_t         res
);

  logic [u2c_pkg::CodeW-1:0] partial_r, partial_nxt;
  logic [u2c_pkg::TailW-1:0] tail_r, tail_nxt;
  logic [u2c_pkg::CodeW-1:0] joined;
  logic [u2c_pkg::TailW-1:0] tail_dec;
  logic [u2c_pkg::ByteW:0]   mapped;

  // Append six payload bits and look up the finished code point
  assign joined   = {partial_r[u2c_pkg::CodeW-7:0], byte_in[5:0]};
  assign tail_dec = tail_r - u2c_pkg::TailOne;
  assign mapped   = u2c_pkg::map_cp(joined);

  // Decide the result and the next sequence state
  always_comb begin
    partial_nxt = partial_r;
    tail_nxt    = tail_r;
    res         = '0;
    if (tail_r == u2c_pkg::TailNone) begin
      if (!byte_in[7]) begin
        res.emit = 1'b1;
        res.data = byte_in;
      end else if (byte_in >= u2c_pkg::Lead2Lo && byte_in <= u2c_pkg::Lead2Hi) begin
        partial_nxt = {{(u2c_pkg::CodeW-5){1'b0}}, byte_in[4:0]};
        tail_nxt    = u2c_pkg::TailOne;
      end else if (byte_in >= u2c_pkg::Lead3Lo && byte_in <= u2c_pkg::Lead3Hi) begin
        partial_nxt = {{(u2c_pkg::CodeW-4){1'b0}}, byte_in[3:0]};
        tail_nxt    = u2c_pkg::TailTwo;
      end else begin
        res.emit = 1'b1;
        res.bad  = 1'b1;
      end
    end else if (byte_in[7:6] != 2'b10) begin
      // Bad tail: drop the pending sequence
      partial_nxt = '0;
      tail_nxt    = u2c_pkg::TailNone;
      res.emit    = 1'b1;
      res.bad     = 1'b1;
    end else if (tail_dec != u2c_pkg::TailNone) begin
      partial_nxt = joined;
      tail_nxt    = tail_dec;
    end else begin
      partial_nxt = '0;
      tail_nxt    = u2c_pkg::TailNone;
      res.emit    = 1'b1;
      res.bad     = ~mapped[u2c_pkg::ByteW];
      res.data    = mapped[u2c_pkg::ByteW] ? mapped[u2c_pkg::ByteW-1:0] : '0;
    end
  end

  // Advance the sequence state on each consumed beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= '0;
      tail_r    <= u2c_pkg::TailNone;
    end else if (step) begin
      partial_r <= partial_nxt;
      tail_r    <= tail_nxt;
    end
  end

`ifndef SYNTH
  // A pending count of three never arises
  a_tail_range: assert property (@(posedge clk) disable iff (!rst_n)
    tail_r != 2'd3) else $error("tail count out of range");

  // An idle decoder holds no partial code
  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    tail_r == u2c_pkg::TailNone |-> partial_r == '0) else $error("stale partial code");

  // A result never comes with a sequence left pending
  a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.emit |=> tail_r == u2c_pkg::TailNone) else $error("result with pending tail");
`endif

endmodule
